>>> hw/rtl/mtep_pkg.sv
// Shared types, byte constants and result codes of the MIDI track event parser.
// No dependencies; used by mtep_front, mtep_fifo, mtep_back, midi_track_event_parser and the bench.
package mtep_pkg;

	// result kinds
	localparam logic [2:0] KIND_CHANNEL    = 3'd0;
	localparam logic [2:0] KIND_META_HDR   = 3'd1;
	localparam logic [2:0] KIND_SYSEX_F0   = 3'd2;
	localparam logic [2:0] KIND_SYSEX_F7   = 3'd3;
	localparam logic [2:0] KIND_BODY       = 3'd4;
	localparam logic [2:0] KIND_TRUNCATED  = 3'd5;
	localparam logic [2:0] KIND_NO_RUNNING = 3'd6;

	// status and data byte codes
	localparam logic [7:0] DATA_MASK     = 8'h7F;
	localparam logic [7:0] STATUS_META   = 8'hFF;
	localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
	localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
	localparam logic [3:0] CLASS_PROGRAM = 4'hC;
	localparam logic [3:0] CLASS_PRESSURE = 4'hD;
	localparam logic [7:0] META_END_OF_TRACK = 8'h2F;

	// one raw byte with the flags the front end derives from it
	typedef struct packed {
		logic [7:0] data;
		logic       is_status;
		logic       is_meta;
		logic       is_sysex;
		logic       one_data;
	} byte_class_t;

	// one result item
	typedef struct packed {
		logic [2:0]  result_kind;
		logic [3:0]  status_class;
		logic [3:0]  channel;
		logic [7:0]  first_data;
		logic [7:0]  second_data;
		logic [7:0]  meta_kind;
		logic [31:0] body_length;
		logic [31:0] delta_ticks;
		logic [31:0] track_tick;
		logic        body_last;
		logic        track_done;
	} result_t;

	// program change and channel pressure carry a single data byte
	function automatic logic one_data_byte(input logic [7:0] status);
		return (status[7:4] == CLASS_PROGRAM) || (status[7:4] == CLASS_PRESSURE);
	endfunction

endpackage

>>> hw/rtl/mtep_front.sv
// Front end of the MIDI track event parser: accepts raw track bytes and tags them.
// Depends on mtep_pkg; feeds the byte queue.
module mtep_front (
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           track_byte,
	input  logic                 queue_full,
	output logic                 push,
	output mtep_pkg::byte_class_t push_item
);

	// stall while the queue has no room
	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	// classify the byte for the parser
	always_comb begin
		push_item.data      = track_byte;
		push_item.is_status = track_byte[7];
		push_item.is_meta   = (track_byte == mtep_pkg::STATUS_META);
		push_item.is_sysex  = (track_byte == mtep_pkg::STATUS_SYSEX) ||
			(track_byte == mtep_pkg::STATUS_ESCAPE);
		push_item.one_data  = mtep_pkg::one_data_byte(track_byte);
	end

endmodule

>>> hw/rtl/mtep_fifo.sv
// Small register queue between the front end and the parser back end.
// Depends on mtep_pkg for the item type.
module mtep_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mtep_pkg::byte_class_t push_item,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output mtep_pkg::byte_class_t pop_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mtep_pkg::byte_class_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	// store the item
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/mtep_back.sv
// Back end of the MIDI track event parser: event state machine and result register.
// Depends on mtep_pkg; takes tagged bytes from the queue.
module mtep_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [31:0]           track_length,
	input  logic                  item_valid,
	input  mtep_pkg::byte_class_t item,
	output logic                  item_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output mtep_pkg::result_t     result
);

	typedef enum logic [2:0] {
		PH_DELTA,
		PH_STATUS,
		PH_DATA1,
		PH_DATA2,
		PH_MTYPE,
		PH_LEN,
		PH_BODY
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [31:0] bytes_left_q, bytes_left_n;
	logic [31:0] acc_q, acc_n;
	logic [31:0] delta_q, delta_n;
	logic [31:0] tick_q, tick_n;
	logic [7:0]  run_status_q, run_status_n;
	logic [7:0]  held_first_q, held_first_n;
	logic [7:0]  held_meta_q, held_meta_n;
	logic [31:0] body_left_q, body_left_n;
	logic        stopped_q, stopped_n;
	logic [7:0]  ev_status_q, ev_status_n;
	logic        ev_one_q, ev_one_n;
	logic [31:0] ev_len_q, ev_len_n;

	logic              out_valid_q;
	mtep_pkg::result_t result_q;
	mtep_pkg::result_t res;
	logic              emit;

	logic [31:0] dec_left;
	logic [31:0] acc_shift;
	logic [31:0] body_dec;
	logic        complete;
	logic        eot;

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign item_pop  = item_valid && (!out_valid_q || !out_stall);

	assign dec_left  = bytes_left_q - 32'd1;
	assign acc_shift = {acc_q[24:0], item.data[6:0]};
	assign body_dec  = body_left_q - 32'd1;

	// parse one byte
	always_comb begin
		phase_n      = phase_q;
		bytes_left_n = bytes_left_q;
		acc_n        = acc_q;
		delta_n      = delta_q;
		tick_n       = tick_q;
		run_status_n = run_status_q;
		held_first_n = held_first_q;
		held_meta_n  = held_meta_q;
		body_left_n  = body_left_q;
		stopped_n    = stopped_q;
		ev_status_n  = ev_status_q;
		ev_one_n     = ev_one_q;
		ev_len_n     = ev_len_q;
		emit         = 1'b0;
		complete     = 1'b0;
		eot          = 1'b0;
		res          = '0;

		if (stopped_q || bytes_left_q == '0) begin
			stopped_n = 1'b1;
		end else begin
			bytes_left_n = dec_left;
			case (phase_q)
				PH_DELTA: begin
					acc_n = acc_shift;
					if (!item.is_status) begin
						delta_n = acc_shift;
						tick_n  = tick_q + acc_shift;
						acc_n   = '0;
						phase_n = PH_STATUS;
					end
				end
				PH_STATUS: begin
					if (item.is_status) begin
						ev_status_n = item.data;
						ev_one_n    = item.one_data;
						if (item.is_meta) begin
							run_status_n = '0;
							phase_n      = PH_MTYPE;
						end else if (item.is_sysex) begin
							run_status_n = '0;
							held_meta_n  = '0;
							acc_n        = '0;
							phase_n      = PH_LEN;
						end else begin
							run_status_n = item.data;
							phase_n      = PH_DATA1;
						end
					end else if (run_status_q == '0) begin
						emit            = 1'b1;
						res.result_kind = mtep_pkg::KIND_NO_RUNNING;
						res.track_done  = 1'b1;
						stopped_n       = 1'b1;
					end else begin
						ev_status_n = run_status_q;
						ev_one_n    = mtep_pkg::one_data_byte(run_status_q);
						if (mtep_pkg::one_data_byte(run_status_q)) begin
							emit             = 1'b1;
							complete         = 1'b1;
							res.result_kind  = mtep_pkg::KIND_CHANNEL;
							res.status_class = run_status_q[7:4];
							res.channel      = run_status_q[3:0];
							res.first_data   = item.data;
						end else begin
							held_first_n = item.data;
							phase_n      = PH_DATA2;
						end
					end
				end
				PH_DATA1: begin
					if (ev_one_q) begin
						emit             = 1'b1;
						complete         = 1'b1;
						res.result_kind  = mtep_pkg::KIND_CHANNEL;
						res.status_class = ev_status_q[7:4];
						res.channel      = ev_status_q[3:0];
						res.first_data   = item.data;
					end else begin
						held_first_n = item.data;
						phase_n      = PH_DATA2;
					end
				end
				PH_DATA2: begin
					emit             = 1'b1;
					complete         = 1'b1;
					res.result_kind  = mtep_pkg::KIND_CHANNEL;
					res.status_class = ev_status_q[7:4];
					res.channel      = ev_status_q[3:0];
					res.first_data   = held_first_q;
					res.second_data  = item.data;
				end
				PH_MTYPE: begin
					held_meta_n = item.data;
					acc_n       = '0;
					phase_n     = PH_LEN;
				end
				PH_LEN: begin
					acc_n = acc_shift;
					if (!item.is_status) begin
						body_left_n = acc_shift;
						ev_len_n    = acc_shift;
						acc_n       = '0;
						emit        = 1'b1;
						if (dec_left < acc_shift) begin
							res.result_kind = mtep_pkg::KIND_TRUNCATED;
							res.track_done  = 1'b1;
							stopped_n       = 1'b1;
						end else begin
							if (ev_status_q == mtep_pkg::STATUS_META) begin
								res.result_kind = mtep_pkg::KIND_META_HDR;
							end else if (ev_status_q == mtep_pkg::STATUS_SYSEX) begin
								res.result_kind = mtep_pkg::KIND_SYSEX_F0;
							end else begin
								res.result_kind = mtep_pkg::KIND_SYSEX_F7;
							end
							res.status_class = ev_status_q[7:4];
							res.channel      = ev_status_q[3:0];
							res.meta_kind    = held_meta_q;
							res.body_length  = acc_shift;
							if (acc_shift == '0) begin
								complete = 1'b1;
								eot      = (ev_status_q == mtep_pkg::STATUS_META) &&
									(held_meta_q == mtep_pkg::META_END_OF_TRACK);
							end else begin
								phase_n = PH_BODY;
							end
						end
					end
				end
				PH_BODY: begin
					body_left_n      = body_dec;
					emit             = 1'b1;
					res.result_kind  = mtep_pkg::KIND_BODY;
					res.status_class = ev_status_q[7:4];
					res.channel      = ev_status_q[3:0];
					res.first_data   = item.data;
					res.meta_kind    = held_meta_q;
					res.body_length  = ev_len_q;
					res.body_last    = (body_dec == '0);
					if (body_dec == '0) begin
						complete = 1'b1;
						eot      = (ev_status_q == mtep_pkg::STATUS_META) &&
							(held_meta_q == mtep_pkg::META_END_OF_TRACK);
					end
				end
				default: begin
					phase_n = PH_DELTA;
				end
			endcase

			// finish the event, or stop on bytes running out mid-event
			if (complete) begin
				phase_n = PH_DELTA;
				acc_n   = '0;
				if (eot || dec_left == '0) begin
					res.track_done = 1'b1;
					stopped_n      = 1'b1;
				end
			end else if (!emit && dec_left == '0) begin
				if (phase_n == PH_DELTA) begin
					delta_n = '0;
				end
				emit            = 1'b1;
				res             = '0;
				res.result_kind = mtep_pkg::KIND_TRUNCATED;
				res.track_done  = 1'b1;
				stopped_n       = 1'b1;
			end
		end

		res.delta_ticks = delta_n;
		res.track_tick  = tick_n;
	end

	// hold parser state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_DELTA;
			bytes_left_q <= '0;
			acc_q        <= '0;
			delta_q      <= '0;
			tick_q       <= '0;
			run_status_q <= '0;
			held_first_q <= '0;
			held_meta_q  <= '0;
			body_left_q  <= '0;
			stopped_q    <= 1'b1;
			ev_status_q  <= '0;
			ev_one_q     <= 1'b0;
			ev_len_q     <= '0;
			out_valid_q  <= 1'b0;
			result_q     <= '0;
		end else begin
			if (cfg_write) begin
				// restart on a new track
				phase_q      <= PH_DELTA;
				bytes_left_q <= track_length;
				acc_q        <= '0;
				delta_q      <= '0;
				tick_q       <= '0;
				run_status_q <= '0;
				held_first_q <= '0;
				held_meta_q  <= '0;
				body_left_q  <= '0;
				stopped_q    <= (track_length == '0);
				ev_status_q  <= '0;
				ev_one_q     <= 1'b0;
				ev_len_q     <= '0;
			end else if (item_pop) begin
				phase_q      <= phase_n;
				bytes_left_q <= bytes_left_n;
				acc_q        <= acc_n;
				delta_q      <= delta_n;
				tick_q       <= tick_n;
				run_status_q <= run_status_n;
				held_first_q <= held_first_n;
				held_meta_q  <= held_meta_n;
				body_left_q  <= body_left_n;
				stopped_q    <= stopped_n;
				ev_status_q  <= ev_status_n;
				ev_one_q     <= ev_one_n;
				ev_len_q     <= ev_len_n;
			end

			// load a new result, or drop the one taken
			if (item_pop && emit) begin
				out_valid_q <= 1'b1;
				result_q    <= res;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/midi_track_event_parser.sv
// MIDI track event parser: one track byte per item, at most one result per byte.
// Throughput: one byte per cycle unless a stalled result holds it; parsing is combinational.
// Path: an accepted byte is held in the queue, then its result in the result register.
// Reset: queue empty, no result pending, parser stopped until track_length is written.
// Depends on mtep_pkg, mtep_front, mtep_fifo and mtep_back.
module midi_track_event_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] track_length,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  track_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_kind,
	output logic [3:0]  status_class,
	output logic [3:0]  channel,
	output logic [7:0]  first_data,
	output logic [7:0]  second_data,
	output logic [7:0]  meta_kind,
	output logic [31:0] body_length,
	output logic [31:0] delta_ticks,
	output logic [31:0] track_tick,
	output logic        body_last,
	output logic        track_done
);

	mtep_pkg::byte_class_t push_item;
	mtep_pkg::byte_class_t pop_item;
	mtep_pkg::result_t     result;
	logic                  push;
	logic                  queue_full;
	logic                  item_valid;
	logic                  item_pop;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	mtep_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.track_byte (track_byte),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	mtep_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (item_pop),
		.not_empty (item_valid),
		.pop_item  (pop_item)
	);

	mtep_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_valid && cfg_ready),
		.track_length (track_length),
		.item_valid   (item_valid),
		.item         (pop_item),
		.item_pop     (item_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result       (result)
	);

	// unpack the result item
	assign result_kind  = result.result_kind;
	assign status_class = result.status_class;
	assign channel      = result.channel;
	assign first_data   = result.first_data;
	assign second_data  = result.second_data;
	assign meta_kind    = result.meta_kind;
	assign body_length  = result.body_length;
	assign delta_ticks  = result.delta_ticks;
	assign track_tick   = result.track_tick;
	assign body_last    = result.body_last;
	assign track_done   = result.track_done;

endmodule

>>> tb/midi_track_event_parser_test.sv
// Self-checking bench for midi_track_event_parser: track chunks go in a byte per item,
// results come back checked against a predictor of the event parse kept in this file.
// Depends on mtep_pkg and the midi_track_event_parser RTL.
module midi_track_event_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mtep_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD = 150;
	localparam int RANDOM_BYTES = 900;

	typedef enum logic [2:0] {
		AT_DELTA, AT_STATUS, AT_DATA1, AT_DATA2, AT_META_TYPE, AT_LENGTH, AT_BODY
	} parse_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] track_length = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  track_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  result_kind;
	logic [3:0]  status_class;
	logic [3:0]  channel;
	logic [7:0]  first_data;
	logic [7:0]  second_data;
	logic [7:0]  meta_kind;
	logic [31:0] body_length;
	logic [31:0] delta_ticks;
	logic [31:0] track_tick;
	logic        body_last;
	logic        track_done;

	logic [7:0] pending_bytes[$];
	logic [7:0] track_bytes[$];
	result_t    awaited_results[$];
	int         mismatch_count = 0;
	int         quiet_cycles = 0;
	int         hold_requests = 0;
	int         holds_done = 0;

	// predictor copy of the parser state
	logic [31:0]  trk_bytes_left;
	parse_phase_t trk_phase;
	logic [31:0]  trk_number;
	logic [31:0]  trk_delta;
	logic [31:0]  trk_tick;
	logic [7:0]   trk_running;
	logic [7:0]   trk_first_data;
	logic [7:0]   trk_meta_kind;
	logic [31:0]  trk_body_left;
	logic         trk_stopped;
	logic [7:0]   trk_status;
	logic [31:0]  trk_body_length;

	// generator state for well-formed events
	bit         running_ok;
	logic [7:0] last_status;

	midi_track_event_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.track_length(track_length),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.track_byte(track_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.status_class(status_class),
		.channel(channel),
		.first_data(first_data),
		.second_data(second_data),
		.meta_kind(meta_kind),
		.body_length(body_length),
		.delta_ticks(delta_ticks),
		.track_tick(track_tick),
		.body_last(body_last),
		.track_done(track_done)
	);

	always #1 clk = ~clk;

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < 40)
			$display("%0t: %s: got %0h, want %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// clear the parse for a new track of the given byte count
	function automatic void restart_track(input logic [31:0] len);
		trk_bytes_left = len;
		trk_phase = AT_DELTA;
		trk_number = '0;
		trk_delta = '0;
		trk_tick = '0;
		trk_running = '0;
		trk_first_data = '0;
		trk_meta_kind = '0;
		trk_body_left = '0;
		trk_status = '0;
		trk_body_length = '0;
		trk_stopped = (len == 0);
	endfunction

	function automatic result_t event_result(input logic [2:0] kind, input logic [7:0] st,
			input logic [7:0] d1, input logic [7:0] d2, input logic [7:0] mk,
			input logic [31:0] blen, input bit last, input bit done);
		result_t res;
		res.result_kind = kind;
		res.status_class = st[7:4];
		res.channel = st[3:0];
		res.first_data = d1;
		res.second_data = d2;
		res.meta_kind = mk;
		res.body_length = blen;
		res.delta_ticks = trk_delta;
		res.track_tick = trk_tick;
		res.body_last = last;
		res.track_done = done;
		return res;
	endfunction

	// advance the parse by one byte; returns 1 when the byte yields a result
	function automatic bit parse_track_byte(input logic [7:0] b, output result_t res);
		bit made;
		bit complete;
		bit at_end;
		bit take_first;
		logic [2:0] hdr_kind;
		made = 1'b0;
		complete = 1'b0;
		at_end = 1'b0;
		take_first = 1'b0;
		res = '0;
		if (trk_stopped || trk_bytes_left == 0) begin
			trk_stopped = 1'b1;
			return 1'b0;
		end
		trk_bytes_left--;
		case (trk_phase)
		AT_DELTA: begin
			trk_number = (trk_number << 7) | 32'(b & DATA_MASK);
			if (!b[7]) begin
				trk_delta = trk_number;
				trk_tick += trk_number;
				trk_number = '0;
				trk_phase = AT_STATUS;
			end
		end
		AT_STATUS: begin
			if (b[7]) begin
				trk_status = b;
				if (b == STATUS_META) begin
					trk_running = '0;
					trk_phase = AT_META_TYPE;
				end else if (b == STATUS_SYSEX || b == STATUS_ESCAPE) begin
					trk_running = '0;
					trk_meta_kind = '0;
					trk_number = '0;
					trk_phase = AT_LENGTH;
				end else begin
					trk_running = b;
					trk_phase = AT_DATA1;
				end
			end else if (trk_running == 0) begin
				res = event_result(KIND_NO_RUNNING, 8'h00, 8'h00, 8'h00, 8'h00, '0, 1'b0, 1'b1);
				trk_stopped = 1'b1;
				return 1'b1;
			end else begin
				trk_status = trk_running;
				take_first = 1'b1;
			end
		end
		AT_DATA1: take_first = 1'b1;
		AT_DATA2: begin
			res = event_result(KIND_CHANNEL, trk_status, trk_first_data, b, 8'h00, '0,
				1'b0, 1'b0);
			made = 1'b1;
			complete = 1'b1;
		end
		AT_META_TYPE: begin
			trk_meta_kind = b;
			trk_number = '0;
			trk_phase = AT_LENGTH;
		end
		AT_LENGTH: begin
			trk_number = (trk_number << 7) | 32'(b & DATA_MASK);
			if (!b[7]) begin
				trk_body_left = trk_number;
				trk_body_length = trk_number;
				trk_number = '0;
				// body cannot fit in what is left of the track
				if (trk_bytes_left < trk_body_left) begin
					res = event_result(KIND_TRUNCATED, 8'h00, 8'h00, 8'h00, 8'h00, '0,
						1'b0, 1'b1);
					trk_stopped = 1'b1;
					return 1'b1;
				end
				if (trk_status == STATUS_META)
					hdr_kind = KIND_META_HDR;
				else if (trk_status == STATUS_SYSEX)
					hdr_kind = KIND_SYSEX_F0;
				else
					hdr_kind = KIND_SYSEX_F7;
				res = event_result(hdr_kind, trk_status, 8'h00, 8'h00, trk_meta_kind,
					trk_body_length, 1'b0, 1'b0);
				made = 1'b1;
				if (trk_body_left == 0) begin
					complete = 1'b1;
					at_end = (trk_status == STATUS_META) &&
						(trk_meta_kind == META_END_OF_TRACK);
				end else begin
					trk_phase = AT_BODY;
				end
			end
		end
		default: begin
			trk_body_left--;
			res = event_result(KIND_BODY, trk_status, b, 8'h00, trk_meta_kind,
				trk_body_length, trk_body_left == 0, 1'b0);
			made = 1'b1;
			if (trk_body_left == 0) begin
				complete = 1'b1;
				at_end = (trk_status == STATUS_META) && (trk_meta_kind == META_END_OF_TRACK);
			end
		end
		endcase
		// first data byte: program change and pressure finish here
		if (take_first) begin
			if (trk_status[7:4] == CLASS_PROGRAM || trk_status[7:4] == CLASS_PRESSURE) begin
				res = event_result(KIND_CHANNEL, trk_status, b, 8'h00, 8'h00, '0, 1'b0, 1'b0);
				made = 1'b1;
				complete = 1'b1;
			end else begin
				trk_first_data = b;
				trk_phase = AT_DATA2;
			end
		end
		if (complete) begin
			trk_phase = AT_DELTA;
			trk_number = '0;
			if (at_end || trk_bytes_left == 0) begin
				res.track_done = 1'b1;
				trk_stopped = 1'b1;
			end
			return made;
		end
		// bytes ran out inside an event
		if (!made && trk_bytes_left == 0) begin
			if (trk_phase == AT_DELTA)
				trk_delta = '0;
			res = event_result(KIND_TRUNCATED, 8'h00, 8'h00, 8'h00, 8'h00, '0, 1'b0, 1'b1);
			trk_stopped = 1'b1;
			return 1'b1;
		end
		return made;
	endfunction

	// append a variable-length number, with optional leading zero groups
	function automatic void push_number(input logic [31:0] value, input int pad);
		int groups;
		logic [31:0] part;
		groups = 1;
		while (groups < 5 && (value >> (7 * groups)) != 0)
			groups++;
		repeat (pad) track_bytes.push_back(8'h80);
		for (int i = groups - 1; i >= 0; i--) begin
			part = value >> (7 * i);
			track_bytes.push_back({i != 0, part[6:0]});
		end
	endfunction

	function automatic void push_body(input int count);
		repeat (count) track_bytes.push_back(8'($urandom()));
	endfunction

	// append one well-formed event with random content
	function automatic void add_event();
		int pick;
		int body;
		logic [7:0] status;
		logic [7:0] meta;
		logic [3:0] nib;
		bit one_byte;
		pick = $urandom_range(0, 9);
		push_number(($urandom_range(0, 3) == 0) ? ($urandom() >> $urandom_range(0, 31)) :
			$urandom_range(0, 100), ($urandom_range(0, 19) == 0) ? 1 : 0);
		body = ($urandom_range(0, 29) == 0) ? $urandom_range(128, 160) : $urandom_range(0, 5);
		if (pick < 6) begin
			if (running_ok && $urandom_range(0, 2) == 0) begin
				// running status: first data byte must look like data
				status = last_status;
				track_bytes.push_back(8'($urandom_range(0, 127)));
			end else begin
				if ($urandom_range(0, 7) == 0) begin
					do nib = 4'($urandom_range(1, 14)); while (nib == 4'h7);
					status = {4'hF, nib};
				end else begin
					status = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
				end
				track_bytes.push_back(status);
				last_status = status;
				running_ok = 1'b1;
				track_bytes.push_back(($urandom_range(0, 7) == 0) ?
					8'($urandom_range(128, 255)) : 8'($urandom_range(0, 127)));
			end
			one_byte = (status[7:4] == CLASS_PROGRAM) || (status[7:4] == CLASS_PRESSURE);
			if (!one_byte)
				track_bytes.push_back(($urandom_range(0, 7) == 0) ?
					8'($urandom_range(128, 255)) : 8'($urandom_range(0, 127)));
		end else if (pick < 8) begin
			meta = 8'($urandom());
			if ($urandom_range(0, 9) == 0)
				meta = META_END_OF_TRACK;
			else if (meta == META_END_OF_TRACK)
				meta = 8'h03;
			track_bytes.push_back(STATUS_META);
			track_bytes.push_back(meta);
			push_number(body, 0);
			push_body(body);
			running_ok = 1'b0;
		end else begin
			track_bytes.push_back($urandom_range(0, 1) ? STATUS_SYSEX : STATUS_ESCAPE);
			push_number(body, 0);
			push_body(body);
			running_ok = 1'b0;
		end
	endfunction

	task automatic settle();
		while (pending_bytes.size() != 0 || in_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_track_length(input logic [31:0] len);
		@(posedge clk);
		cfg_valid <= 1'b1;
		track_length <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		restart_track(len);
	endtask

	task automatic feed_track(input bit split);
		int cut;
		cut = split ? track_bytes.size() / 2 : track_bytes.size();
		for (int i = 0; i < cut; i++)
			pending_bytes.push_back(track_bytes[i]);
		if (split)
			settle();
		for (int i = cut; i < track_bytes.size(); i++)
			pending_bytes.push_back(track_bytes[i]);
		settle();
	endtask

	task automatic play_track(input logic [31:0] len, input bit split);
		write_track_length(len);
		feed_track(split);
	endtask

	// stimulus: directed tracks, then random tracks
	initial begin : stimulus
		int fed;
		int track_no;
		int shape;
		logic [31:0] len;
		restart_track('0);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// no length written yet: bytes are dropped
		track_bytes = '{8'h00, 8'h90, 8'h3C};
		feed_track(1'b0);

		// channel messages, running status, longest delta, odd status, end of track,
		// then bytes past the end
		track_bytes = '{8'h00, 8'h90, 8'h3C, 8'h7F, 8'h00, 8'h3C, 8'h00,
			8'h81, 8'h00, 8'hC5, 8'h10, 8'h00, 8'h10,
			8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hF3, 8'h01, 8'h82,
			8'h00, 8'hFF, 8'h2F, 8'h00, 8'h00, 8'h90};
		play_track(32'd24, 1'b0);

		// over-long delta, pitch bend, pressure, both sysex kinds, meta body ending by count
		track_bytes = '{8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hE3, 8'h00, 8'h7F,
			8'h00, 8'hD2, 8'h7F, 8'h00, 8'hF0, 8'h01, 8'h11, 8'h00, 8'hF7, 8'h00,
			8'h00, 8'hFF, 8'h51, 8'h02, 8'h07, 8'hA1};
		play_track(32'd24, 1'b0);

		// data byte with no running status
		track_bytes = '{8'h00, 8'h40, 8'h00};
		play_track(32'd3, 1'b0);

		// body longer than the bytes left
		track_bytes = '{8'h00, 8'hFF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00};
		play_track(32'd8, 1'b0);

		// cut short inside a delta, then just after a status byte
		track_bytes = '{8'h81};
		play_track(32'd1, 1'b0);
		track_bytes = '{8'h00, 8'h90};
		play_track(32'd2, 1'b0);

		// zero length keeps the parser stopped
		track_bytes = '{8'h00, 8'h90, 8'h3C, 8'h7F};
		play_track(32'd0, 1'b0);

		// largest length, with a full drain halfway through
		track_bytes.delete();
		running_ok = 1'b0;
		repeat (10) add_event();
		play_track(32'hFFFF_FFFF, 1'b1);

		fed = 0;
		track_no = 0;
		while (fed < RANDOM_BYTES) begin
			track_bytes.delete();
			running_ok = 1'b0;
			shape = $urandom_range(0, 9);
			if (shape == 8 && track_no != 3) begin
				// noise
				push_body($urandom_range(1, 20));
				len = $urandom_range(1, track_bytes.size() + 2);
			end else begin
				repeat ((track_no == 3) ? 40 : $urandom_range(1, 8)) add_event();
				if ($urandom_range(0, 1)) begin
					push_number($urandom_range(0, 100), 0);
					track_bytes.push_back(STATUS_META);
					track_bytes.push_back(META_END_OF_TRACK);
					track_bytes.push_back(8'h00);
				end
				len = track_bytes.size();
				if (shape == 6)
					len = $urandom_range(1, track_bytes.size());
				else if (shape == 7) begin
					push_body($urandom_range(1, 6));
					len = track_bytes.size();
				end else if (shape == 9)
					len = $urandom();
			end
			// hold the output off for a long stretch on one track
			if (track_no == 3)
				hold_requests++;
			play_track(len, $urandom_range(0, 5) == 0);
			fed += (len < track_bytes.size()) ? int'(len) : track_bytes.size();
			track_no++;
		end

		settle();
		if (awaited_results.size() != 0)
			flag_mismatch("results never delivered", 32'(awaited_results.size()), 0);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// drive bytes in bursts with random gaps; predict each accepted byte
	always @(posedge clk or negedge arst_n) begin : drive_bytes
		result_t produced;
		int burst_left;
		int gap_left;
		if (!arst_n) begin
			in_valid <= 1'b0;
			track_byte <= '0;
			burst_left = 8;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall && parse_track_byte(track_byte, produced))
				awaited_results.push_back(produced);
			// hold while stalled, else move on
			if (!(in_valid && in_stall)) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (pending_bytes.size() != 0) begin
					in_valid <= 1'b1;
					track_byte <= pending_bytes.pop_front();
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output stall: random modes, plus a long hold when requested
	always @(posedge clk or negedge arst_n) begin : stall_results
		int stall_mode;
		int mode_left;
		int hold_left;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode = 0;
			mode_left = 0;
			hold_left = 0;
		end else if (hold_left == 0 && holds_done != hold_requests) begin
			holds_done++;
			hold_left = LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(10, 120);
			end else begin
				mode_left--;
			end
			case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// compare each delivered result with the oldest prediction
	always @(posedge clk) begin : check_results
		result_t seen;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen = {result_kind, status_class, channel, first_data, second_data, meta_kind,
				body_length, delta_ticks, track_tick, body_last, track_done};
			if (awaited_results.size() == 0) begin
				flag_mismatch("result with none awaited, kind", 32'(seen.result_kind), 0);
			end else begin
				want = awaited_results.pop_front();
				if (seen.result_kind !== want.result_kind)
					flag_mismatch("result_kind", 32'(seen.result_kind),
						32'(want.result_kind));
				if (seen.status_class !== want.status_class)
					flag_mismatch("status_class", 32'(seen.status_class),
						32'(want.status_class));
				if (seen.channel !== want.channel)
					flag_mismatch("channel", 32'(seen.channel), 32'(want.channel));
				if (seen.first_data !== want.first_data)
					flag_mismatch("first_data", 32'(seen.first_data), 32'(want.first_data));
				if (seen.second_data !== want.second_data)
					flag_mismatch("second_data", 32'(seen.second_data),
						32'(want.second_data));
				if (seen.meta_kind !== want.meta_kind)
					flag_mismatch("meta_kind", 32'(seen.meta_kind), 32'(want.meta_kind));
				if (seen.body_length !== want.body_length)
					flag_mismatch("body_length", seen.body_length, want.body_length);
				if (seen.delta_ticks !== want.delta_ticks)
					flag_mismatch("delta_ticks", seen.delta_ticks, want.delta_ticks);
				if (seen.track_tick !== want.track_tick)
					flag_mismatch("track_tick", seen.track_tick, want.track_tick);
				if (seen.body_last !== want.body_last)
					flag_mismatch("body_last", 32'(seen.body_last), 32'(want.body_last));
				if (seen.track_done !== want.track_done)
					flag_mismatch("track_done", 32'(seen.track_done), 32'(want.track_done));
			end
		end
	end

	// end the run when no handshake happens for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

>>> sim.f
hw/rtl/mtep_pkg.sv
hw/rtl/mtep_front.sv
hw/rtl/mtep_fifo.sv
hw/rtl/mtep_back.sv
hw/rtl/midi_track_event_parser.sv
tb/midi_track_event_parser_test.sv
